>>> rtl/sbc_pkg.sv
// sbc_pkg: operation codes, fixed field widths and the result struct
// shared by the shader binding cache top level and its update logic.
// No dependencies.
package sbc_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned KEY_W   = 16;
  localparam int unsigned STAMP_W = 16;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned PTR_W   = 5;

  typedef enum logic [OP_W-1:0] {
    OP_BIND       = 2'd0,
    OP_INVALIDATE = 2'd1,
    OP_INIT       = 2'd2,
    OP_RESERVED   = 2'd3
  } sbc_op_t;

  typedef struct packed {
    logic              needs_rebind;
    logic [SLOT_W-1:0] slot;
  } sbc_result_t;

endpackage

>>> rtl/sbc_bind_update.sv
// sbc_bind_update: next value of one batch record for one operation.
// Depends on sbc_pkg. Pure combinational logic between the record read
// register and the memory write port.
module sbc_bind_update
  import sbc_pkg::*;
#(
  parameter int unsigned WAYS       = 5,
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned STAMP_BITS = 16
) (
  input  sbc_op_t                              op,
  input  logic [KEY_BITS-1:0]                  key,
  input  logic [STAMP_BITS-1:0]                stamp,
  input  logic [WAYS-1:0][KEY_BITS-1:0]        keys,
  input  logic [WAYS-1:0][STAMP_BITS-1:0]      stamps,
  input  logic [SLOT_W-1:0]                    act,
  input  logic [PTR_W-1:0]                     ptr,
  output logic [WAYS-1:0][KEY_BITS-1:0]        keys_next,
  output logic [WAYS-1:0][STAMP_BITS-1:0]      stamps_next,
  output logic [SLOT_W-1:0]                    act_next,
  output logic [PTR_W-1:0]                     ptr_next,
  output sbc_result_t                          result
);

  logic              act_hit;
  logic              found;
  logic              rebind;
  logic [SLOT_W-1:0] sel;
  logic [PTR_W-1:0]  rr;

  // active slot check and in-order scan (first key match or first empty)
  always_comb begin
    act_hit = 1'b0;
    found   = 1'b0;
    rebind  = 1'b1;
    sel     = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (act == SLOT_W'(i) && keys[i] == key && stamps[i] == stamp) begin
        act_hit = 1'b1;
      end
      if (!found && (keys[i] == key || keys[i] == '0)) begin
        found  = 1'b1;
        sel    = SLOT_W'(i);
        rebind = !(keys[i] == key && stamps[i] == stamp);
      end
    end
  end

  // round-robin victim, wraps once the pointer reaches WAYS
  assign rr = (ptr >= PTR_W'(WAYS)) ? '0 : ptr;

  always_comb begin
    keys_next           = keys;
    stamps_next         = stamps;
    act_next            = act;
    ptr_next            = ptr;
    result.needs_rebind = 1'b0;
    unique case (op)
      OP_BIND: begin
        if (!act_hit) begin
          if (!found) begin
            ptr_next = rr + PTR_W'(1);
          end
          for (int i = 0; i < WAYS; i++) begin
            if ((found && sel == SLOT_W'(i)) || (!found && rr == PTR_W'(i))) begin
              keys_next[i]   = key;
              stamps_next[i] = stamp;
            end
          end
          act_next            = found ? sel : rr[SLOT_W-1:0];
          result.needs_rebind = found ? rebind : 1'b1;
        end
      end
      OP_INVALIDATE: begin
        stamps_next = '0;
      end
      OP_INIT: begin
        act_next     = '0;
        ptr_next     = PTR_W'(1);
        keys_next[0] = '0;
      end
      default: begin
      end
    endcase
    result.slot = act_next;
  end

endmodule

>>> rtl/shader_binding_cache_unit.sv
// shader_binding_cache_unit: per-batch shader binding cache, top level.
// Depends on sbc_pkg and sbc_bind_update. Holds the batch record memory,
// the item/result handshakes and the control sequencer.
//
//  channel | signals                                          | dir | beat
//  --------+--------------------------------------------------+-----+--------------------------
//  input   | in_valid/in_ready, operation, batch_index,       | in  | one operation on a batch
//          | shader_key, shader_stamp                         |     |
//  result  | out_valid/out_ready, needs_rebind, slot,         | out | one result per input beat
//          | bad_index                                        |     |
//
// Steps: in S_IDLE an input beat is accepted and its batch record read;
//   in S_EXEC the record is updated and written back on commit.
//   A new beat is taken only once the previous one is written back.
// Stalls: the result sits in an output register; while it waits, the next
//   beat is still taken and read, and its write-back waits for the register.
// Reset: synchronous; per-batch valid flags clear at once, a batch whose
//   flag is low reads as an all-zero record. No clearing pass is needed.
module shader_binding_cache_unit
  import sbc_pkg::*;
#(
  parameter int unsigned WAYS        = 5,
  parameter int unsigned NUM_BATCHES = 16,
  parameter int unsigned KEY_BITS    = 16,
  parameter int unsigned STAMP_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    operation,
  input  logic [INDEX_W-1:0] batch_index,
  input  logic [KEY_W-1:0]   shader_key,
  input  logic [STAMP_W-1:0] shader_stamp,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               needs_rebind,
  output logic [SLOT_W-1:0]  slot,
  output logic               bad_index
);

  localparam int unsigned AW    = (NUM_BATCHES > 1) ? $clog2(NUM_BATCHES) : 1;
  localparam int unsigned KW    = WAYS * KEY_BITS;
  localparam int unsigned SW    = WAYS * STAMP_BITS;
  localparam int unsigned ROW_W = KW + SW + SLOT_W + PTR_W;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state;

  // item registers
  sbc_op_t               op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [STAMP_BITS-1:0] stamp_q;
  logic                  bad_q;
  logic [AW-1:0]         addr_q;

  // record memory: {ptr, active, stamps, keys} per batch
  logic [ROW_W-1:0]       mem [NUM_BATCHES];
  logic [ROW_W-1:0]       rd_row;
  logic                   rd_valid;
  logic [NUM_BATCHES-1:0] row_valid;
  logic [ROW_W-1:0]       row;
  logic [ROW_W-1:0]       row_next;

  logic [WAYS-1:0][KEY_BITS-1:0]   keys, keys_next;
  logic [WAYS-1:0][STAMP_BITS-1:0] stamps, stamps_next;
  logic [SLOT_W-1:0]               act, act_next;
  logic [PTR_W-1:0]                ptr, ptr_next;
  sbc_result_t                     result;

  logic          accept;
  logic          commit;
  logic          in_bad;
  logic [AW-1:0] in_addr;
  logic [63:0]   key_wide;
  logic [63:0]   stamp_wide;

  // keys and stamps are kept at the configured width
  assign key_wide   = {{(64 - KEY_W){1'b0}}, shader_key};
  assign stamp_wide = {{(64 - STAMP_W){1'b0}}, shader_stamp};

  // out-of-range batches fold onto batch 0
  assign in_bad  = ({1'b0, batch_index} >= (INDEX_W + 1)'(NUM_BATCHES));
  assign in_addr = in_bad ? '0 : batch_index[AW-1:0];

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  // write back only once the output register can take the result
  assign commit   = (state == S_EXEC) && (!out_valid || out_ready);

  // never-written batches read as zero
  assign row = rd_valid ? rd_row : '0;
  assign {ptr, act, stamps, keys} = row;
  assign row_next = {ptr_next, act_next, stamps_next, keys_next};

  sbc_bind_update #(
    .WAYS       (WAYS),
    .KEY_BITS   (KEY_BITS),
    .STAMP_BITS (STAMP_BITS)
  ) u_update (
    .op          (op_q),
    .key         (key_q),
    .stamp       (stamp_q),
    .keys        (keys),
    .stamps      (stamps),
    .act         (act),
    .ptr         (ptr),
    .keys_next   (keys_next),
    .stamps_next (stamps_next),
    .act_next    (act_next),
    .ptr_next    (ptr_next),
    .result      (result)
  );

  // memory: read on accept, write on commit; the two never share a cycle
  always_ff @(posedge clk) begin
    if (commit) begin
      mem[addr_q] <= row_next;
    end
    if (accept) begin
      rd_row <= mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state    <= S_EXEC;
            rd_valid <= row_valid[in_addr];
          end
        end
        S_EXEC: begin
          if (commit) begin
            state             <= S_IDLE;
            row_valid[addr_q] <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= sbc_op_t'(operation);
      key_q   <= key_wide[KEY_BITS-1:0];
      stamp_q <= stamp_wide[STAMP_BITS-1:0];
      bad_q   <= in_bad;
      addr_q  <= in_addr;
    end
    if (commit) begin
      needs_rebind <= result.needs_rebind;
      slot         <= result.slot;
      bad_index    <= bad_q;
    end
  end

endmodule

>>> rtl/sbc_checker.sv
// sbc_checker: port-level checks for shader_binding_cache_unit, and the
// bind that attaches it. Depends on sbc_pkg.
module sbc_checker
  import sbc_pkg::*;
#(
  parameter int unsigned WAYS = 5
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [OP_W-1:0]    operation,
  input logic [INDEX_W-1:0] batch_index,
  input logic [KEY_W-1:0]   shader_key,
  input logic [STAMP_W-1:0] shader_stamp,
  input logic               out_valid,
  input logic               out_ready,
  input logic               needs_rebind,
  input logic [SLOT_W-1:0]  slot,
  input logic               bad_index
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(needs_rebind)
      && $stable(bad_index))
    else $error("result changed while stalled");

  // one item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous item in flight");

  // a result appears only after an update cycle
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a processed item");

  // reported slot is always a real way
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> slot < SLOT_W'(WAYS))
    else $error("slot out of range");

endmodule

bind shader_binding_cache_unit sbc_checker #(.WAYS(WAYS)) u_sbc_checker (.*);

>>> tb/testbench.sv
// testbench: self-checking bench for shader_binding_cache_unit.
// Depends on sbc_pkg and the RTL top level. Directed bind, invalidate, init and
// bad index cases run first, then random traffic with gaps on both channels.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sbc_pkg::*;

  // Must match the parameters passed to the instance below.
  localparam int unsigned WAYS        = 5;
  localparam int unsigned NUM_BATCHES = 16;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic [OP_W-1:0]    operation    = '0;
  logic [INDEX_W-1:0] batch_index  = '0;
  logic [KEY_W-1:0]   shader_key   = '0;
  logic [STAMP_W-1:0] shader_stamp = '0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic               needs_rebind;
  logic [SLOT_W-1:0]  slot;
  logic               bad_index;

  shader_binding_cache_unit #(
    .WAYS       (WAYS),
    .NUM_BATCHES(NUM_BATCHES),
    .KEY_BITS   (KEY_W),
    .STAMP_BITS (STAMP_W)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .batch_index (batch_index),
    .shader_key  (shader_key),
    .shader_stamp(shader_stamp),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .needs_rebind(needs_rebind),
    .slot        (slot),
    .bad_index   (bad_index)
  );

  always #1 clk = ~clk;

  // Expected result of one input beat, tagged with its beat number.
  typedef struct {
    logic              needs_rebind;
    logic [SLOT_W-1:0] slot;
    logic              bad_index;
    int unsigned       beat;
  } bind_result_t;

  bind_result_t pending_results[$];
  int unsigned  beats_sent     = 0;
  int unsigned  mismatch_count = 0;
  // When set, neither side inserts gaps: back-to-back stretches.
  bit           quiet          = 1'b0;

  // Shadow copy of the per-batch records.
  logic [KEY_W-1:0]   cached_key   [NUM_BATCHES][WAYS];
  logic [STAMP_W-1:0] cached_stamp [NUM_BATCHES][WAYS];
  logic [SLOT_W-1:0]  cur_slot     [NUM_BATCHES];
  logic [PTR_W-1:0]   rr_ptr       [NUM_BATCHES];

  // Updates the shadow records for one accepted beat and returns its result.
  function automatic bind_result_t predict_binding(input sbc_op_t op,
                                                   input logic [INDEX_W-1:0] idx,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [STAMP_W-1:0] stamp);
    bind_result_t r;
    int unsigned  b;
    int unsigned  w;
    int unsigned  pick;
    int unsigned  p;
    bit           active_hit;
    r           = '{default: '0};
    r.bad_index = (idx >= NUM_BATCHES);
    b           = r.bad_index ? 0 : 32'(idx);
    case (op)
      OP_BIND: begin
        active_hit = 1'b0;
        if (cur_slot[b] < WAYS)
          active_hit = (cached_key[b][cur_slot[b]] == key) &&
                       (cached_stamp[b][cur_slot[b]] == stamp);
        if (!active_hit) begin
          r.needs_rebind = 1'b1;
          pick           = WAYS;
          // First slot holding this key, or first empty one, in order.
          for (w = 0; w < WAYS && pick == WAYS; w++) begin
            if (cached_key[b][w] == key) begin
              pick = w;
              if (cached_stamp[b][w] == stamp) r.needs_rebind = 1'b0;
            end else if (cached_key[b][w] == '0) begin
              pick = w;
            end
          end
          // Nothing found: round-robin victim, pointer wraps at WAYS.
          if (pick == WAYS) begin
            p = 32'(rr_ptr[b]);
            if (p >= WAYS) p = 0;
            rr_ptr[b] = PTR_W'(p + 1);
            pick = p;
          end
          cached_key[b][pick]   = key;
          cached_stamp[b][pick] = stamp;
          cur_slot[b]           = SLOT_W'(pick);
        end
      end
      OP_INVALIDATE: begin
        for (w = 0; w < WAYS; w++) cached_stamp[b][w] = '0;
      end
      OP_INIT: begin
        cur_slot[b]      = '0;
        rr_ptr[b]        = PTR_W'(1);
        cached_key[b][0] = '0;
      end
      default: begin
      end
    endcase
    r.slot = cur_slot[b];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned beat,
                                 input logic [15:0] want, input logic [15:0] got);
    $display("beat %0d: %s expected %0h got %0h", beat, what, want, got);
    mismatch_count++;
  endtask

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sends one beat. Valid is only lowered when a gap precedes the beat, so a
  // back-to-back beat never sees valid dropped and raised in one step.
  task automatic send_beat(input sbc_op_t op, input logic [INDEX_W-1:0] idx,
                           input logic [KEY_W-1:0] key, input logic [STAMP_W-1:0] stamp);
    int unsigned  gap;
    bind_result_t want;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    batch_index  <= idx;
    shader_key   <= key;
    shader_stamp <= stamp;
    do @(posedge clk); while (!in_ready);
    want      = predict_binding(op, idx, key, stamp);
    want.beat = beats_sent;
    beats_sent++;
    pending_results.push_back(want);
  endtask

  // Result side: compare each accepted beat with the oldest expectation and
  // stall out_ready at random. Values read here are the pre-edge ones.
  initial begin
    int unsigned  hold;
    bind_result_t want;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending, slot", beats_sent, 16'd0,
                          16'(slot));
        end else begin
          want = pending_results.pop_front();
          if (needs_rebind !== want.needs_rebind)
            report_mismatch("needs_rebind", want.beat, 16'(want.needs_rebind),
                            16'(needs_rebind));
          if (slot !== want.slot)
            report_mismatch("slot", want.beat, 16'(want.slot), 16'(slot));
          if (bad_index !== want.bad_index)
            report_mismatch("bad_index", want.beat, 16'(want.bad_index), 16'(bad_index));
        end
      end
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        hold = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  // Fill a batch, hit through scan and active slot, then force round-robin
  // eviction until the pointer wraps.
  task automatic test_fill_and_replace();
    int unsigned k;
    send_beat(OP_BIND, 8'd3, 16'h0000, 16'h0000);     // active hit on empty record
    send_beat(OP_BIND, 8'd3, 16'h0000, 16'h0005);     // key zero matches empty slot
    send_beat(OP_BIND, 8'd3, 16'hFFFF, 16'hFFFF);     // takes empty slot 0
    for (k = 1; k <= 4; k++)
      send_beat(OP_BIND, 8'd3, KEY_W'(k * 10), 16'h0001);
    send_beat(OP_BIND, 8'd3, 16'd50, 16'h0001);       // full: pointer 0
    send_beat(OP_BIND, 8'd3, 16'd20, 16'h0001);       // scan hit, same stamp
    send_beat(OP_BIND, 8'd3, 16'd20, 16'h0001);       // active hit
    send_beat(OP_BIND, 8'd3, 16'd30, 16'h0007);       // scan hit, new stamp
    for (k = 6; k <= 9; k++)
      send_beat(OP_BIND, 8'd3, KEY_W'(k * 10), 16'h0002);
    send_beat(OP_BIND, 8'd3, 16'd100, 16'h0000);      // pointer at WAYS wraps
    send_beat(OP_BIND, 8'd15, 16'hFFFF, 16'h0000);    // last valid batch
  endtask

  task automatic test_invalidate_and_init();
    send_beat(OP_INVALIDATE, 8'd3, 16'h0000, 16'h0000);
    send_beat(OP_BIND, 8'd3, 16'd100, 16'h0000);      // stamp zero survives invalidate
    send_beat(OP_BIND, 8'd3, 16'd60, 16'h0002);       // stamp was cleared: rebind
    send_beat(OP_INIT, 8'd3, 16'hFFFF, 16'hFFFF);
    send_beat(OP_BIND, 8'd3, 16'h1234, 16'h0003);     // slot 0 empty again
    send_beat(OP_RESERVED, 8'd15, 16'hFFFF, 16'hFFFF); // unused code: no change
  endtask

  // Out-of-range batch numbers fold onto batch 0 for every operation.
  task automatic test_bad_index();
    send_beat(OP_BIND, 8'd16, 16'hABCD, 16'h0001);
    send_beat(OP_BIND, 8'd255, 16'hABCD, 16'h0001);
    send_beat(OP_INVALIDATE, 8'd255, 16'h0000, 16'h0000);
    send_beat(OP_INIT, 8'd200, 16'h0000, 16'h0000);
    send_beat(OP_RESERVED, 8'h80, 16'h5555, 16'hAAAA);
    send_beat(OP_BIND, 8'd0, 16'hABCD, 16'h0001);
  endtask

  // Phases of 100 beats over a few batches and a small key pool so that hits,
  // evictions and wraps are frequent; every third phase runs without gaps.
  task automatic test_random_traffic(input int unsigned total);
    logic [KEY_W-1:0]   key_pool   [7];
    logic [STAMP_W-1:0] stamp_pool [3];
    logic [INDEX_W-1:0] batch_pool [3];
    int unsigned        n;
    int unsigned        k;
    int unsigned        r;
    sbc_op_t            op;
    logic [INDEX_W-1:0] idx;
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stamp;
    for (n = 0; n < total; n++) begin
      if (n % 100 == 0) begin
        quiet = ((n / 100) % 3 == 2);
        for (k = 0; k < 7; k++) key_pool[k] = 16'($urandom);
        if ($urandom_range(0, 1) == 0) key_pool[0] = '0;
        for (k = 0; k < 3; k++) begin
          stamp_pool[k] = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom);
          batch_pool[k] = INDEX_W'($urandom_range(0, NUM_BATCHES - 1));
        end
      end
      r = $urandom_range(0, 99);
      if (r < 76)      op = OP_BIND;
      else if (r < 86) op = OP_INVALIDATE;
      else if (r < 94) op = OP_INIT;
      else             op = OP_RESERVED;
      r = $urandom_range(0, 99);
      if (r < 80)      idx = batch_pool[$urandom_range(0, 2)];
      else if (r < 92) idx = INDEX_W'($urandom_range(NUM_BATCHES, 255));
      else             idx = INDEX_W'($urandom_range(0, 255));
      key   = ($urandom_range(0, 9) == 0) ? 16'($urandom) : key_pool[$urandom_range(0, 6)];
      stamp = ($urandom_range(0, 7) == 0) ? 16'($urandom) : stamp_pool[$urandom_range(0, 2)];
      send_beat(op, idx, key, stamp);
    end
    quiet = 1'b0;
  endtask

  initial begin
    int unsigned b;
    int unsigned w;
    for (b = 0; b < NUM_BATCHES; b++) begin
      cur_slot[b] = '0;
      rr_ptr[b]   = '0;
      for (w = 0; w < WAYS; w++) begin
        cached_key[b][w]   = '0;
        cached_stamp[b][w] = '0;
      end
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_fill_and_replace();
    test_invalidate_and_init();
    test_bad_index();
    test_random_traffic(1100);

    in_valid <= 1'b0;
    // Drain; the watchdog below catches results that never come.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (all long gaps and stalls).
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
rtl/sbc_pkg.sv
rtl/sbc_bind_update.sv
rtl/shader_binding_cache_unit.sv
rtl/sbc_checker.sv
tb/testbench.sv
